// ----- rtl/subcarrier_resource_unit_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Subcarrier resource unit allocator assertion macros
// Clocked assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SUBCARRIER_RESOURCE_UNIT_ALLOCATOR_DEFINES_SVH
`define SUBCARRIER_RESOURCE_UNIT_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
// Check a property while reset is released.
`define SRUA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property at every clock edge, reset included.
`define SRUA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRUA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SRUA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/srua_pkg.sv -----
// ----------------------------------------------------------------------------
// Subcarrier resource unit allocator package
// Shared constants, tables, result codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package srua_pkg;

  localparam int unsigned NUM_SC    = 12;
  localparam int unsigned RES_DEPTH = 19;
  localparam int unsigned BUSY_W    = 17;
  localparam int unsigned TIME_W    = 24;

  typedef enum logic [2:0] {
    STS_TICKED = 3'd0,
    STS_ALLOC  = 3'd1,
    STS_RESV   = 3'd2,
    STS_REFUSE = 3'd3,
    STS_NOFIT  = 3'd4
  } status_t;

  // Unit duration in microseconds for each tone configuration.
  function automatic logic [13:0] unit_dur(input logic [1:0] c);
    logic [13:0] d;
    unique case (c)
      2'd0: d = 14'd8000;
      2'd1: d = 14'd4000;
      2'd2: d = 14'd2000;
      default: d = 14'd1000;
    endcase
    return d;
  endfunction

  function automatic logic [3:0] sc_per_unit(input logic [1:0] c);
    logic [3:0] n;
    unique case (c)
      2'd0: n = 4'd1;
      2'd1: n = 4'd3;
      2'd2: n = 4'd6;
      default: n = 4'd12;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] last_unit(input logic [1:0] c);
    logic [3:0] n;
    unique case (c)
      2'd0: n = 4'd11;
      2'd1: n = 4'd3;
      2'd2: n = 4'd1;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // First reservation entry of each configuration.
  function automatic logic [4:0] res_offset(input logic [1:0] c);
    logic [4:0] n;
    unique case (c)
      2'd0: n = 5'd0;
      2'd1: n = 5'd12;
      2'd2: n = 5'd16;
      default: n = 5'd18;
    endcase
    return n;
  endfunction

  typedef struct packed {
    logic load;
    logic do_tick;
    logic calc_lhs;
    logic idx_clr;
    logic idx_inc;
    logic take_conf;
    logic alloc_init;
    logic n_dec;
    logic alloc_commit;
    logic rsv_init;
    logic rsv_eval;
    logic rsv_commit;
    logic res_tick;
    logic res_nofit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic fits;
    logic idx_last_conf;
    logic unit_ok;
    logic idx_last_unit;
    logic n_too_big;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/srua_ctrl.sv -----
// ----------------------------------------------------------------------------
// Subcarrier resource unit allocator controller
// Sequences tick, configuration choice, unit scan, shortening and reservation.
// ----------------------------------------------------------------------------
module srua_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  srua_pkg::sts_t  sts,
  output srua_pkg::cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_DECODE  = 10'b00_0000_0010,
    S_TICK    = 10'b00_0000_0100,
    S_LHS     = 10'b00_0000_1000,
    S_CHOOSE  = 10'b00_0001_0000,
    S_SCAN    = 10'b00_0010_0000,
    S_SHORT   = 10'b00_0100_0000,
    S_RSV     = 10'b00_1000_0000,
    S_RSV_END = 10'b01_0000_0000,
    S_EMIT    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = sts.kind ? S_LHS : S_TICK;
      end
      S_TICK: begin
        cmd.do_tick  = 1'b1;
        cmd.res_tick = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_LHS: begin
        cmd.calc_lhs = 1'b1;
        cmd.idx_clr  = 1'b1;
        state_nxt    = S_CHOOSE;
      end
      S_CHOOSE: begin
        priority if (sts.fits) begin
          cmd.take_conf = 1'b1;
          cmd.idx_clr   = 1'b1;
          state_nxt     = S_SCAN;
        end else if (sts.idx_last_conf) begin
          cmd.res_nofit = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SCAN: begin
        priority if (sts.unit_ok) begin
          cmd.alloc_init = 1'b1;
          state_nxt      = S_SHORT;
        end else if (sts.idx_last_unit) begin
          cmd.idx_clr  = 1'b1;
          cmd.rsv_init = 1'b1;
          state_nxt    = S_RSV;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SHORT: begin
        if (sts.n_too_big) begin
          cmd.n_dec = 1'b1;
        end else begin
          cmd.alloc_commit = 1'b1;
          state_nxt        = S_EMIT;
        end
      end
      S_RSV: begin
        cmd.rsv_eval = 1'b1;
        if (sts.idx_last_unit) begin
          state_nxt = S_RSV_END;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_RSV_END: begin
        cmd.rsv_commit = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/srua_dpath.sv -----
// ----------------------------------------------------------------------------
// Subcarrier resource unit allocator datapath
// Busy and reservation state, per-unit views, arithmetic and result register.
// ----------------------------------------------------------------------------
`include "subcarrier_resource_unit_allocator_defines.svh"

module srua_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srua_pkg::cmd_t                cmd,
  output srua_pkg::sts_t                sts,
  input  logic                          cfg_wr_en,
  input  logic [7:0]                    cfg_wr_data,
  input  logic                          in_kind,
  input  logic [srua_pkg::TIME_W-1:0]   in_elapsed_us,
  input  logic [3:0]                    in_units_wanted,
  input  logic [srua_pkg::TIME_W-1:0]   in_max_delay_us,
  input  logic [srua_pkg::TIME_W-1:0]   in_waited_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [1:0]                    out_tone_config,
  output logic [3:0]                    out_unit_index,
  output logic [3:0]                    out_first_subcarrier,
  output logic [3:0]                    out_units_granted,
  output logic [srua_pkg::BUSY_W-1:0]   out_busy_until_us
);

  localparam int unsigned BW = srua_pkg::BUSY_W;
  localparam int unsigned TW = srua_pkg::TIME_W;

  function automatic logic [BW-1:0] max2(input logic [BW-1:0] a, input logic [BW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic [BW-1:0] busy_r [srua_pkg::NUM_SC];
  logic [BW-1:0] lim_r  [srua_pkg::RES_DEPTH];
  logic [7:0]    margin_r;
  logic          kind_r;
  logic [TW-1:0] elapsed_r, maxd_r, waited_r;
  logic [3:0]    nru_r;
  logic [32:0]   lhs_r;
  logic [1:0]    conf_r;
  logic [3:0]    idx_r, n_r, best_idx_r;
  logic [BW-1:0] best_r;
  logic          have_r;

  logic [2:0]    res_status_r;
  logic [1:0]    res_conf_r;
  logic [3:0]    res_idx_r, res_first_r, res_granted_r;
  logic [BW-1:0] res_busy_r;

  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [1:0]    out_conf_r;
  logic [3:0]    out_idx_r, out_first_r, out_granted_r;
  logic [BW-1:0] out_busy_r;

  // Blocked time and worst busy time of every unit of every configuration.
  logic [BW-1:0] bt0 [12];
  logic [BW-1:0] bt1 [4];
  logic [BW-1:0] bt2 [2];
  logic [BW-1:0] bt3;
  logic [BW-1:0] mx1 [4];
  logic [BW-1:0] mx2 [2];
  logic [BW-1:0] mx3;

  always_comb begin
    bt3 = lim_r[18];
    for (int i = 0; i < 2; i++) begin
      bt2[i] = (bt3 != '0) ? bt3 : lim_r[16 + i];
    end
    for (int i = 0; i < 4; i++) begin
      bt1[i] = (bt2[i / 2] != '0) ? bt2[i / 2] : lim_r[12 + i];
    end
    for (int i = 0; i < 12; i++) begin
      bt0[i] = (bt1[i / 3] != '0) ? bt1[i / 3] : lim_r[i];
    end
    for (int i = 0; i < 4; i++) begin
      mx1[i] = max2(max2(busy_r[3 * i], busy_r[3 * i + 1]), busy_r[3 * i + 2]);
    end
    for (int i = 0; i < 2; i++) begin
      mx2[i] = max2(mx1[2 * i], mx1[2 * i + 1]);
    end
    mx3 = max2(mx2[0], mx2[1]);
  end

  logic [BW-1:0] bt_sel, mx_sel;
  logic [13:0]   dur_sel, dur_c;
  logic [17:0]   n_prod, busy_prod, nru_prod;
  logic [3:0]    n_fin;
  logic [BW-1:0] busy_new;
  logic [24:0]   rhs_sum, rsv_sum;
  logic [32:0]   rhs;
  logic [7:0]    first_prod, best_first_prod;

  always_comb begin
    unique case (conf_r)
      2'd0: begin
        bt_sel = bt0[idx_r];
        mx_sel = busy_r[idx_r];
      end
      2'd1: begin
        bt_sel = bt1[idx_r[1:0]];
        mx_sel = mx1[idx_r[1:0]];
      end
      2'd2: begin
        bt_sel = bt2[idx_r[0]];
        mx_sel = mx2[idx_r[0]];
      end
      default: begin
        bt_sel = bt3;
        mx_sel = mx3;
      end
    endcase
  end

  assign dur_sel   = srua_pkg::unit_dur(conf_r);
  assign dur_c     = srua_pkg::unit_dur(idx_r[1:0]);
  assign n_prod    = {14'd0, n_r} * {4'd0, dur_sel};
  // Counts of seven and nine are not valid grants once a reservation limits them.
  assign n_fin     = ((bt_sel != '0) && (n_r == 4'd7 || n_r == 4'd9)) ? n_r - 4'd1 : n_r;
  assign busy_prod = {14'd0, n_fin} * {4'd0, dur_sel};
  assign busy_new  = busy_prod[BW-1:0];
  assign nru_prod  = {14'd0, nru_r} * {4'd0, dur_c};
  assign rhs_sum   = {7'd0, nru_prod} + {1'b0, waited_r};
  assign rhs       = {rhs_sum, 8'd0};
  assign rsv_sum   = {1'b0, waited_r} + {8'd0, best_r};
  assign first_prod      = {4'd0, idx_r} * {4'd0, srua_pkg::sc_per_unit(conf_r)};
  assign best_first_prod = {4'd0, best_idx_r} * {4'd0, srua_pkg::sc_per_unit(conf_r)};

  assign sts.kind          = kind_r;
  assign sts.fits          = (lhs_r >= rhs);
  assign sts.idx_last_conf = (idx_r == 4'd3);
  assign sts.unit_ok       = (mx_sel == '0) &&
                             !((bt_sel != '0) && ({3'd0, dur_sel} > bt_sel));
  assign sts.idx_last_unit = (idx_r == srua_pkg::last_unit(conf_r));
  assign sts.n_too_big     = (bt_sel != '0) && ({1'b0, bt_sel} < n_prod);
  assign sts.out_free      = !out_valid_r || !out_stall;

  logic rsv_ok;
  assign rsv_ok = have_r && ({1'b0, maxd_r} > rsv_sum);

  // Control, configuration and allocation state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r    <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < srua_pkg::NUM_SC; j++) begin
        busy_r[j] <= '0;
      end
      for (int k = 0; k < srua_pkg::RES_DEPTH; k++) begin
        lim_r[k] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        margin_r <= cfg_wr_data;
      end
      if (cmd.do_tick) begin
        for (int j = 0; j < srua_pkg::NUM_SC; j++) begin
          busy_r[j] <= ({7'd0, busy_r[j]} > elapsed_r) ? busy_r[j] - elapsed_r[BW-1:0] : '0;
        end
        for (int k = 0; k < srua_pkg::RES_DEPTH; k++) begin
          lim_r[k] <= ({7'd0, lim_r[k]} > elapsed_r) ? lim_r[k] - elapsed_r[BW-1:0] : '0;
        end
      end
      if (cmd.alloc_commit) begin
        for (int j = 0; j < srua_pkg::NUM_SC; j++) begin
          unique case (conf_r)
            2'd0: if (4'(j) == idx_r) busy_r[j] <= busy_new;
            2'd1: if (4'(j / 3) == idx_r) busy_r[j] <= busy_new;
            2'd2: if (4'(j / 6) == idx_r) busy_r[j] <= busy_new;
            default: busy_r[j] <= busy_new;
          endcase
        end
      end
      if (cmd.rsv_commit && rsv_ok) begin
        for (int k = 0; k < srua_pkg::RES_DEPTH; k++) begin
          if (5'(k) == srua_pkg::res_offset(conf_r) + {1'b0, best_idx_r}) begin
            lim_r[k] <= best_r;
          end
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item working registers and result words.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      elapsed_r <= in_elapsed_us;
      nru_r     <= in_units_wanted;
      maxd_r    <= in_max_delay_us;
      waited_r  <= in_waited_us;
    end
    if (cmd.calc_lhs) begin
      lhs_r <= {24'd0, 9'd256 - {1'b0, margin_r}} * {9'd0, maxd_r};
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 4'd1;
    end
    if (cmd.take_conf) begin
      conf_r <= idx_r[1:0];
    end
    if (cmd.alloc_init) begin
      n_r <= nru_r;
    end else if (cmd.n_dec) begin
      n_r <= n_r - 4'd1;
    end
    if (cmd.rsv_init) begin
      have_r <= 1'b0;
    end else if (cmd.rsv_eval && bt_sel == '0 && (!have_r || mx_sel < best_r)) begin
      have_r     <= 1'b1;
      best_r     <= mx_sel;
      best_idx_r <= idx_r;
    end

    if (cmd.res_tick || cmd.res_nofit) begin
      res_status_r  <= cmd.res_tick ? srua_pkg::STS_TICKED : srua_pkg::STS_NOFIT;
      res_conf_r    <= '0;
      res_idx_r     <= '0;
      res_first_r   <= '0;
      res_granted_r <= '0;
      res_busy_r    <= '0;
    end
    if (cmd.alloc_commit) begin
      res_status_r  <= srua_pkg::STS_ALLOC;
      res_conf_r    <= conf_r;
      res_idx_r     <= idx_r;
      res_first_r   <= first_prod[3:0];
      res_granted_r <= n_fin;
      res_busy_r    <= busy_new;
    end
    if (cmd.rsv_commit) begin
      res_conf_r    <= conf_r;
      res_granted_r <= '0;
      if (rsv_ok) begin
        res_status_r <= srua_pkg::STS_RESV;
        res_idx_r    <= best_idx_r;
        res_first_r  <= best_first_prod[3:0];
        res_busy_r   <= best_r;
      end else begin
        res_status_r <= srua_pkg::STS_REFUSE;
        res_idx_r    <= '0;
        res_first_r  <= '0;
        res_busy_r   <= '0;
      end
    end

    if (cmd.out_load) begin
      out_status_r  <= res_status_r;
      out_conf_r    <= res_conf_r;
      out_idx_r     <= res_idx_r;
      out_first_r   <= res_first_r;
      out_granted_r <= res_granted_r;
      out_busy_r    <= res_busy_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_tone_config      = out_conf_r;
  assign out_unit_index       = out_idx_r;
  assign out_first_subcarrier = out_first_r;
  assign out_units_granted    = out_granted_r;
  assign out_busy_until_us    = out_busy_r;

  `SRUA_ASSERT(a_alloc_free, clk, rst_n, cmd.alloc_commit |-> (mx_sel == '0), "allocated unit busy")
  `SRUA_ASSERT(a_grant_le, clk, rst_n, cmd.alloc_commit |-> (n_fin <= nru_r), "grant above request")
  `SRUA_ASSERT(a_rsv_unblk, clk, rst_n, (cmd.rsv_commit && rsv_ok) |-> !(have_r && bt_sel != '0 && idx_r == best_idx_r), "reserved blocked unit")
  `SRUA_ASSERT(a_out_hold, clk, rst_n, (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_busy_r)), "stalled word lost")

endmodule

// ----- rtl/subcarrier_resource_unit_allocator.sv -----
// ----------------------------------------------------------------------------
// Subcarrier resource unit allocator
// Tracks subcarrier busy times and reservation limits and grants resource units.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid/in_stall) are either ticks (in_kind = 0), which age
//   all busy times and reservation limits by in_elapsed_us, or requests
//   (in_kind = 1), which pick a tone configuration and allocate, reserve or
//   refuse a unit. Every input word yields exactly one output word on
//   out_valid/out_stall. The user writes delay_margin through cfg_wr_en and
//   cfg_wr_data only while the block is idle; the block does not enforce this.
//   A tick passes from acceptance through the decode and tick states to the
//   emit state and the output register. A request is decoded, computes its
//   delay bound, tries configurations in turn (up to 4), scans the units of
//   the chosen one (up to 12) and shortens a grant in up to 14 steps; when
//   no unit is free, a reservation pass visits every unit instead. A request
//   that fits no configuration ends after the choice. The sequencer steps
//   one unit per cycle. One word is worked on at a time; in_stall is low
//   only when idle, so the next word is taken only once the result is
//   loaded and the block is idle again. A new word may be taken while the
//   previous result still waits in the output register. When the receiver
//   stalls, the result holds and the block waits before loading the next one.
//   Reset clears all busy times, reservation limits and delay_margin.
// ----------------------------------------------------------------------------
module subcarrier_resource_unit_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [7:0]                    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [srua_pkg::TIME_W-1:0]   in_elapsed_us,
  input  logic [3:0]                    in_units_wanted,
  input  logic [srua_pkg::TIME_W-1:0]   in_max_delay_us,
  input  logic [srua_pkg::TIME_W-1:0]   in_waited_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [1:0]                    out_tone_config,
  output logic [3:0]                    out_unit_index,
  output logic [3:0]                    out_first_subcarrier,
  output logic [3:0]                    out_units_granted,
  output logic [srua_pkg::BUSY_W-1:0]   out_busy_until_us
);

  srua_pkg::cmd_t cmd;
  srua_pkg::sts_t sts;

  srua_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  srua_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_kind              (in_kind),
    .in_elapsed_us        (in_elapsed_us),
    .in_units_wanted      (in_units_wanted),
    .in_max_delay_us      (in_max_delay_us),
    .in_waited_us         (in_waited_us),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_tone_config      (out_tone_config),
    .out_unit_index       (out_unit_index),
    .out_first_subcarrier (out_first_subcarrier),
    .out_units_granted    (out_units_granted),
    .out_busy_until_us    (out_busy_until_us)
  );

endmodule
